### hdl/tkgt_pkg.sv
// Package for the temperature keyed gain table: payload structs, op codes,
// register indexes and the control/status structs between controller and datapath.
// No dependencies.
package tkgt_pkg;

    localparam int TEMP_W  = 16;
    localparam int GAIN_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int OP_W    = 2;
    localparam int REG_W   = 3;
    localparam int CFG_W   = 32;
    localparam int BEST_W  = 9;

    localparam logic [BEST_W-1:0] NEAR_LIMIT = BEST_W'(500);

    localparam logic [OP_W-1:0] OP_RECORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_CHOOSE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

    localparam logic [REG_W-1:0] REG_BED_TEMP    = 3'd0;
    localparam logic [REG_W-1:0] REG_HOTEND_TEMP = 3'd1;
    localparam logic [REG_W-1:0] REG_BED_KP      = 3'd2;
    localparam logic [REG_W-1:0] REG_BED_KI      = 3'd3;
    localparam logic [REG_W-1:0] REG_BED_KD      = 3'd4;
    localparam logic [REG_W-1:0] REG_HOTEND_KP   = 3'd5;
    localparam logic [REG_W-1:0] REG_HOTEND_KI   = 3'd6;
    localparam logic [REG_W-1:0] REG_HOTEND_KD   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              kind;
        logic [TEMP_W-1:0] temperature;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              matched;
        logic [TEMP_W-1:0] slot_temperature;
        logic [GAIN_W-1:0] out_p;
        logic [GAIN_W-1:0] out_i;
        logic [GAIN_W-1:0] out_d;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

### hdl/tkgt_dp.sv
// Datapath: both gain tables, default registers, slot scan and result register.
// Depends on tkgt_pkg; driven by tkgt_ctrl commands.
module tkgt_dp #(
    parameter int SLOTS = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tkgt_pkg::REG_W-1:0]   cfg_index,
    input  logic [tkgt_pkg::CFG_W-1:0]   cfg_data,
    input  tkgt_pkg::in_item_t           in_data,
    output tkgt_pkg::out_item_t          out_data,
    input  tkgt_pkg::dp_cmd_t            cmd,
    output tkgt_pkg::dp_status_t         status
);
    import tkgt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TEMP_W-1:0] tag_reg [2][SLOTS];
    logic [GAIN_W-1:0] p_reg   [2][SLOTS];
    logic [GAIN_W-1:0] i_reg   [2][SLOTS];
    logic [GAIN_W-1:0] d_reg   [2][SLOTS];

    logic [TEMP_W-1:0] def_temp_reg [2];
    logic [GAIN_W-1:0] def_p_reg    [2];
    logic [GAIN_W-1:0] def_i_reg    [2];
    logic [GAIN_W-1:0] def_d_reg    [2];

    in_item_t          cur_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  at_reg;
    logic              hit_reg;
    logic [BEST_W-1:0] best_reg;
    out_item_t         out_reg;

    logic [TEMP_W-1:0] scan_tag;
    logic [TEMP_W-1:0] scan_diff;
    logic              scan_eq;
    logic              scan_closer;
    out_item_t         out_next;

    always_comb
    begin
        scan_tag    = tag_reg[cur_reg.kind][idx_reg];
        scan_eq     = (scan_tag == cur_reg.temperature);
        scan_diff   = (cur_reg.temperature >= scan_tag) ? cur_reg.temperature - scan_tag
                                                        : scan_tag - cur_reg.temperature;
        scan_closer = (scan_diff < TEMP_W'(best_reg));
        status.scan_last = (idx_reg == IDX_W'(SLOTS - 1));
    end

    always_comb
    begin
        out_next.slot             = '0;
        out_next.matched          = 1'b0;
        out_next.slot_temperature = tag_reg[cur_reg.kind][0];
        out_next.out_p            = p_reg[cur_reg.kind][0];
        out_next.out_i            = i_reg[cur_reg.kind][0];
        out_next.out_d            = d_reg[cur_reg.kind][0];
        case (cur_reg.op)
            OP_RECORD:
            begin
                out_next.slot             = hit_reg ? SLOT_W'(at_reg) : '0;
                out_next.matched          = hit_reg;
                out_next.slot_temperature = cur_reg.temperature;
                out_next.out_p            = cur_reg.gain_p;
                out_next.out_i            = cur_reg.gain_i;
                out_next.out_d            = cur_reg.gain_d;
            end
            OP_CHOOSE:
            begin
                out_next.slot             = SLOT_W'(at_reg);
                out_next.matched          = hit_reg;
                out_next.slot_temperature = tag_reg[cur_reg.kind][at_reg];
                out_next.out_p            = p_reg[cur_reg.kind][at_reg];
                out_next.out_i            = i_reg[cur_reg.kind][at_reg];
                out_next.out_d            = d_reg[cur_reg.kind][at_reg];
            end
            OP_RESTORE:
            begin
                out_next.slot_temperature = def_temp_reg[cur_reg.kind];
                out_next.out_p            = def_p_reg[cur_reg.kind];
                out_next.out_i            = def_i_reg[cur_reg.kind];
                out_next.out_d            = def_d_reg[cur_reg.kind];
            end
            default:
            begin
            end
        endcase
    end

    // default registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                def_temp_reg[k] <= '0;
                def_p_reg[k]    <= '0;
                def_i_reg[k]    <= '0;
                def_d_reg[k]    <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BED_TEMP:    def_temp_reg[0] <= cfg_data[TEMP_W-1:0];
                REG_HOTEND_TEMP: def_temp_reg[1] <= cfg_data[TEMP_W-1:0];
                REG_BED_KP:      def_p_reg[0]    <= cfg_data;
                REG_BED_KI:      def_i_reg[0]    <= cfg_data;
                REG_BED_KD:      def_d_reg[0]    <= cfg_data;
                REG_HOTEND_KP:   def_p_reg[1]    <= cfg_data;
                REG_HOTEND_KI:   def_i_reg[1]    <= cfg_data;
                REG_HOTEND_KD:   def_d_reg[1]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // command latch and scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg  <= in_data;
            idx_reg  <= '0;
            at_reg   <= '0;
            hit_reg  <= 1'b0;
            best_reg <= NEAR_LIMIT;
        end
        else if (cmd.step)
        begin
            if (!status.scan_last)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cur_reg.op == OP_RECORD && scan_eq && !hit_reg)
            begin
                hit_reg <= 1'b1;
                at_reg  <= idx_reg;
            end
            if (cur_reg.op == OP_CHOOSE && scan_closer)
            begin
                hit_reg  <= 1'b1;
                at_reg   <= idx_reg;
                best_reg <= scan_diff[BEST_W-1:0];
            end
        end
        if (cmd.apply)
            out_reg <= out_next;
    end

    // tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    tag_reg[k][s] <= '0;
                    p_reg[k][s]   <= '0;
                    i_reg[k][s]   <= '0;
                    d_reg[k][s]   <= '0;
                end
            end
        end
        else if (cmd.apply)
        begin
            case (cur_reg.op)
                OP_RECORD:
                begin
                    if (hit_reg)
                    begin
                        p_reg[cur_reg.kind][at_reg] <= cur_reg.gain_p;
                        i_reg[cur_reg.kind][at_reg] <= cur_reg.gain_i;
                        d_reg[cur_reg.kind][at_reg] <= cur_reg.gain_d;
                    end
                    else
                    begin
                        for (int s = 1; s < SLOTS; s++)
                        begin
                            tag_reg[cur_reg.kind][s] <= tag_reg[cur_reg.kind][s-1];
                            p_reg[cur_reg.kind][s]   <= p_reg[cur_reg.kind][s-1];
                            i_reg[cur_reg.kind][s]   <= i_reg[cur_reg.kind][s-1];
                            d_reg[cur_reg.kind][s]   <= d_reg[cur_reg.kind][s-1];
                        end
                        tag_reg[cur_reg.kind][0] <= cur_reg.temperature;
                        p_reg[cur_reg.kind][0]   <= cur_reg.gain_p;
                        i_reg[cur_reg.kind][0]   <= cur_reg.gain_i;
                        d_reg[cur_reg.kind][0]   <= cur_reg.gain_d;
                    end
                end
                OP_RESTORE:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            tag_reg[k][s] <= def_temp_reg[k];
                            p_reg[k][s]   <= def_p_reg[k];
                            i_reg[k][s]   <= def_i_reg[k];
                            d_reg[k][s]   <= def_d_reg[k];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_data = out_reg;

endmodule

### hdl/tkgt_ctrl.sv
// Controller: sequences accept, slot scan and apply; owns the output valid flag.
// Depends on tkgt_pkg.
module tkgt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tkgt_pkg::dp_cmd_t     cmd,
    input  tkgt_pkg::dp_status_t  status
);
    import tkgt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cmd.load  = in_valid && in_ready;
        cmd.step  = (state_reg == ST_SCAN);
        cmd.apply = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cmd.load) state_next = ST_SCAN;
            ST_SCAN:  if (status.scan_last) state_next = ST_APPLY;
            ST_APPLY: if (cmd.apply) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase

        if (cmd.apply)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/temperature_keyed_gain_table.sv
// Temperature keyed gain table, top level: bed and hotend tables of SLOTS entries
// each (tag plus p/i/d gain words), with record, choose-nearest and restore.
// Depends on tkgt_pkg, tkgt_ctrl, tkgt_dp.
//
// A command is latched at its input transfer. The datapath then compares one
// slot per cycle against the key, for all SLOTS slots. An apply step then
// updates the table and registers the result, raising out_valid; it waits
// while an earlier result is still held by a low out_ready. One command is in
// flight at a time. The next is accepted in the cycle after the result is
// registered, while that result may still be waiting for out_ready. Default
// registers are to be written through cfg_we/cfg_index/cfg_data only while
// no command is in flight; the block itself does not enforce this.
module temperature_keyed_gain_table #(
    parameter int SLOTS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tkgt_pkg::REG_W-1:0]  cfg_index,
    input  logic [tkgt_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tkgt_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tkgt_pkg::out_item_t         out_data
);
    import tkgt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tkgt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tkgt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### hdl/tkgt_checker.sv
// Port-level checker for the temperature keyed gain table, bound to the top level.
// Depends on tkgt_pkg and temperature_keyed_gain_table.
module tkgt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  tkgt_pkg::out_item_t         out_data
);
    import tkgt_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // one command in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready right after a transfer");

    // the scan comes between an accepted command and its result
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(out_valid))
        else $error("result appeared too early");

    // block goes idle as soon as a result is registered
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("block not idle after producing a result");

endmodule

bind temperature_keyed_gain_table tkgt_checker u_tkgt_checker (.*);

### tb/tb_temperature_keyed_gain_table.sv
// Testbench for temperature_keyed_gain_table: directed and random record, choose,
// restore and unused-op commands, checked against an in-bench table predictor.
// Depends on tkgt_pkg and the temperature_keyed_gain_table RTL.
`timescale 1ns / 1ps

module tb_temperature_keyed_gain_table;

    import tkgt_pkg::*;

    localparam int SLOTS = 5;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [REG_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;

    // predicted table contents; bed in 0..SLOTS-1, hotend in SLOTS..2*SLOTS-1
    logic [TEMP_W-1:0] tag_mem [2*SLOTS] = '{default: '0};
    logic [GAIN_W-1:0] p_mem   [2*SLOTS] = '{default: '0};
    logic [GAIN_W-1:0] i_mem   [2*SLOTS] = '{default: '0};
    logic [GAIN_W-1:0] d_mem   [2*SLOTS] = '{default: '0};
    logic [CFG_W-1:0]  default_reg [8]   = '{default: '0};

    out_item_t pending_responses [$];

    bit idling = 1'b1;
    int mismatches = 0;
    int quiet_cycles = 0;
    int n_records = 0;
    int n_overwrites = 0;
    int n_chooses = 0;
    int n_near = 0;
    int n_restores = 0;
    int n_unused = 0;

    temperature_keyed_gain_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic out_item_t table_response(input in_item_t c);
        out_item_t   r;
        int          base;
        int          at;
        logic        hit;
        logic [31:0] best;
        logic [31:0] delta;
        base = c.kind ? SLOTS : 0;
        at = 0;
        hit = 1'b0;
        case (c.op)
            OP_RECORD:
            begin
                n_records++;
                for (int s = 0; s < SLOTS; s++)
                    if (!hit && tag_mem[base + s] == c.temperature)
                    begin
                        hit = 1'b1;
                        at = s;
                    end
                if (hit)
                    n_overwrites++;
                else
                begin
                    for (int s = SLOTS - 1; s > 0; s--)
                    begin
                        tag_mem[base + s] = tag_mem[base + s - 1];
                        p_mem[base + s] = p_mem[base + s - 1];
                        i_mem[base + s] = i_mem[base + s - 1];
                        d_mem[base + s] = d_mem[base + s - 1];
                    end
                    tag_mem[base] = c.temperature;
                end
                p_mem[base + at] = c.gain_p;
                i_mem[base + at] = c.gain_i;
                d_mem[base + at] = c.gain_d;
            end
            OP_CHOOSE:
            begin
                n_chooses++;
                best = 32'(NEAR_LIMIT);
                for (int s = 0; s < SLOTS; s++)
                begin
                    delta = (c.temperature >= tag_mem[base + s])
                          ? 32'(c.temperature) - 32'(tag_mem[base + s])
                          : 32'(tag_mem[base + s]) - 32'(c.temperature);
                    if (delta < best)
                    begin
                        best = delta;
                        at = s;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    n_near++;
            end
            OP_RESTORE:
            begin
                n_restores++;
                for (int s = 0; s < SLOTS; s++)
                begin
                    tag_mem[s] = default_reg[REG_BED_TEMP][TEMP_W-1:0];
                    p_mem[s] = default_reg[REG_BED_KP];
                    i_mem[s] = default_reg[REG_BED_KI];
                    d_mem[s] = default_reg[REG_BED_KD];
                    tag_mem[SLOTS + s] = default_reg[REG_HOTEND_TEMP][TEMP_W-1:0];
                    p_mem[SLOTS + s] = default_reg[REG_HOTEND_KP];
                    i_mem[SLOTS + s] = default_reg[REG_HOTEND_KI];
                    d_mem[SLOTS + s] = default_reg[REG_HOTEND_KD];
                end
            end
            default:
                n_unused++;
        endcase
        r.slot = SLOT_W'(at);
        r.matched = hit;
        r.slot_temperature = tag_mem[base + at];
        r.out_p = p_mem[base + at];
        r.out_i = i_mem[base + at];
        r.out_d = d_mem[base + at];
        return r;
    endfunction

    function automatic in_item_t command(input logic [OP_W-1:0] op, input logic kind,
                                         input logic [TEMP_W-1:0] temperature,
                                         input logic [GAIN_W-1:0] gp, gi, gd);
        in_item_t c;
        c.op = op;
        c.kind = kind;
        c.temperature = temperature;
        c.gain_p = gp;
        c.gain_i = gi;
        c.gain_d = gd;
        return c;
    endfunction

    // temperatures cluster on stored tags so that overwrites, near hits and the
    // 499/500 boundary come up often
    function automatic in_item_t random_command();
        in_item_t          c;
        int unsigned       pick;
        logic [TEMP_W-1:0] anchor;
        logic [TEMP_W-1:0] offset;
        c.gain_p = $urandom();
        c.gain_i = $urandom();
        c.gain_d = $urandom();
        c.kind = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 42)
            c.op = OP_RECORD;
        else if (pick < 89)
            c.op = OP_CHOOSE;
        else if (pick < 95)
            c.op = OP_RESTORE;
        else
            c.op = OP_UNUSED;
        anchor = tag_mem[(c.kind ? SLOTS : 0) + $urandom_range(0, SLOTS - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.temperature = anchor;
            4, 5:
            begin
                offset = TEMP_W'($urandom_range(0, 600));
                c.temperature = $urandom_range(0, 1) ? anchor + offset : anchor - offset;
            end
            6:
            begin
                offset = $urandom_range(0, 1) ? 16'd499 : 16'd500;
                c.temperature = $urandom_range(0, 1) ? anchor + offset : anchor - offset;
            end
            7: c.temperature = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: c.temperature = TEMP_W'($urandom());
        endcase
        return c;
    endfunction

    task automatic send_command(input in_item_t c);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_responses.push_back(table_response(c));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == REG_BED_TEMP || idx == REG_HOTEND_TEMP)
            default_reg[idx] = {16'h0000, value[TEMP_W-1:0]};
        else
            default_reg[idx] = value;
    endtask

    task automatic program_defaults(input logic [CFG_W-1:0] bt, ht, bkp, bki, bkd,
                                    hkp, hki, hkd);
        write_reg(REG_BED_TEMP, bt);
        write_reg(REG_HOTEND_TEMP, ht);
        write_reg(REG_BED_KP, bkp);
        write_reg(REG_BED_KI, bki);
        write_reg(REG_BED_KD, bkd);
        write_reg(REG_HOTEND_KP, hkp);
        write_reg(REG_HOTEND_KI, hki);
        write_reg(REG_HOTEND_KD, hkd);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_contents();
        send_command(command(OP_CHOOSE, 1'b0, 16'h0000, 32'h0, 32'h0, 32'h0));
        send_command(command(OP_CHOOSE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
    endtask

    task automatic test_record_and_evict();
        send_command(command(OP_RECORD, 1'b0, 16'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF));
        send_command(command(OP_RECORD, 1'b0, 16'd1200, 32'h0, 32'h0, 32'h0));
        send_command(command(OP_RECORD, 1'b0, 16'd1000, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h5555_5555));
        for (int t = 1300; t <= 1600; t += 100)
            send_command(command(OP_RECORD, 1'b0, TEMP_W'(t), $urandom(), $urandom(),
                                 $urandom()));
        // 1000 fell off the end, so this is a fresh insert
        send_command(command(OP_RECORD, 1'b0, 16'd1000, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'hAAAA_AAAA));
        send_command(command(OP_RECORD, 1'b1, 16'hFFFF, 32'h8000_0001, 32'h7FFF_FFFE,
                             32'h0000_FFFF));
    endtask

    task automatic test_choose_rules();
        // bed tags now 1000, 1600, 1500, 1400, 1300
        send_command(command(OP_CHOOSE, 1'b0, 16'd1100, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b0, 16'd1550, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b0, 16'd500, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b0, 16'd501, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b0, 16'd2100, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b0, 16'd0, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b1, 16'd65035, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b1, 16'd65036, '0, '0, '0));
        send_command(command(OP_CHOOSE, 1'b1, 16'd0, '0, '0, '0));
    endtask

    task automatic test_unused_op();
        send_command(command(OP_UNUSED, 1'b0, 16'd1600, $urandom(), $urandom(), $urandom()));
        send_command(command(OP_UNUSED, 1'b1, 16'd1234, $urandom(), $urandom(), $urandom()));
    endtask

    task automatic test_restore_defaults();
        drain();
        program_defaults('1, '1, '1, '1, '1, '1, '1, '1);
        send_command(command(OP_RESTORE, 1'b0, 16'd0, $urandom(), $urandom(), $urandom()));
        send_command(command(OP_CHOOSE, 1'b1, 16'hFFFF, '0, '0, '0));
        drain();
        program_defaults($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
        send_command(command(OP_RESTORE, 1'b1, 16'hFFFF, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input int count, input bit with_idling,
                                       input bit zero_defaults);
        drain();
        if (zero_defaults)
            program_defaults('0, '0, '0, '0, '0, '0, '0, '0);
        else
            program_defaults($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom());
        idling = with_idling;
        for (int n = 0; n < count; n++)
        begin
            // hold off until the table is quiet now and then
            if (n == count / 2 || (with_idling && $urandom_range(0, 99) == 0))
                drain();
            send_command(random_command());
        end
        drain();
    endtask

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (idling && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("result transfer with no command outstanding (slot %0d)", out_data.slot);
                mismatches++;
            end
            else
            begin
                want = pending_responses.pop_front();
                compare_field("slot", 32'(want.slot), 32'(out_data.slot));
                compare_field("matched", 32'(want.matched), 32'(out_data.matched));
                compare_field("slot_temperature", 32'(want.slot_temperature),
                              32'(out_data.slot_temperature));
                compare_field("out_p", want.out_p, out_data.out_p);
                compare_field("out_i", want.out_i, out_data.out_i);
                compare_field("out_d", want.out_d, out_data.out_d);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("temperature_keyed_gain_table verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_contents();
        test_record_and_evict();
        test_choose_rules();
        test_unused_op();
        test_restore_defaults();
        test_random_traffic(240, 1'b1, 1'b1);
        test_random_traffic(240, 1'b1, 1'b0);
        test_random_traffic(240, 1'b1, 1'b0);
        test_random_traffic(210, 1'b0, 1'b0);
        repeat (SLOTS + 6) @(posedge clk);
        $display("Covered %0d records (%0d overwrites of an existing tag), %0d chooses",
                 n_records, n_overwrites, n_chooses);
        $display("(%0d within range), %0d restores and %0d unused-op commands.",
                 n_near, n_restores, n_unused);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("temperature_keyed_gain_table verification clean");
        else
            $display("temperature_keyed_gain_table verification failed");
        $finish;
    end

endmodule
